// ----- rtl/single_wire_eeprom_bus_master_unit_defines.svh -----
// Assertion helpers used by the bus master sequencer.
`ifndef SINGLE_WIRE_EEPROM_BUS_MASTER_UNIT_DEFINES_SVH
`define SINGLE_WIRE_EEPROM_BUS_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWEBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWEBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/swebm_pkg.sv -----
package swebm_pkg;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_ACK_TIMEOUT    = 3'd1;
  localparam logic [2:0] ST_ACK_NO_RISE    = 3'd2;
  localparam logic [2:0] ST_NOACK_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_NOACK_LOW      = 3'd4;
  localparam logic [2:0] ST_READ_LOW_LOW   = 3'd5;
  localparam logic [2:0] ST_READ_HIGH_HIGH = 3'd6;

  localparam logic [2:0] REG_HALF_BIT     = 3'd0;
  localparam logic [2:0] REG_READ_FIRST   = 3'd1;
  localparam logic [2:0] REG_READ_TAIL    = 3'd2;
  localparam logic [2:0] REG_ACK_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_STANDBY      = 3'd4;
  localparam logic [2:0] REG_HEADER_LOW   = 3'd5;

  localparam logic [15:0] RST_HALF_BIT    = 16'd50;
  localparam logic [15:0] RST_READ_FIRST  = 16'd25;
  localparam logic [15:0] RST_READ_TAIL   = 16'd25;
  localparam logic [15:0] RST_ACK_TIMEOUT = 16'd200;
  localparam logic [15:0] RST_STANDBY     = 16'd8000;
  localparam logic [15:0] RST_HEADER_LOW  = 16'd200;

  localparam logic [7:0] START_HEADER_BYTE = 8'h55;
  localparam int unsigned MSB_BIT = 7;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_HLOW1 = 5'd1,
    PH_STBY  = 5'd2,
    PH_HLOW2 = 5'd3,
    PH_WR1   = 5'd4,
    PH_WR2   = 5'd5,
    PH_RDA   = 5'd6,
    PH_RDB   = 5'd7,
    PH_RDT   = 5'd8,
    PH_MK1   = 5'd9,
    PH_MK2   = 5'd10,
    PH_SW    = 5'd11,
    PH_SH1   = 5'd12,
    PH_SH2   = 5'd13
  } phase_t;

  // One classified tick as it travels from the front to the sequencer.
  typedef struct packed {
    logic       start;
    logic [1:0] kind;
    logic [7:0] data;
    logic       mack;
    logic       bus;
  } item_t;

  typedef struct packed {
    logic [15:0] half_bit;
    logic [15:0] read_first;
    logic [15:0] read_tail;
    logic [15:0] ack_timeout;
    logic [15:0] standby;
    logic [15:0] header_low;
  } cfg_t;

endpackage

// ----- rtl/swebm_front.sv -----
module swebm_front (
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic               cmd_valid,
  input  logic [1:0]         action,
  input  logic [7:0]         data_byte,
  input  logic               master_ack,
  input  logic               bus_in,
  input  logic               q_full,
  output logic               push,
  output swebm_pkg::item_t   item
);
  import swebm_pkg::*;

  assign tick_stall = q_full;
  assign push       = tick_valid && !q_full;

  // Decode the command: an unused action code starts nothing.
  always_comb begin
    item.start = cmd_valid && (action != ACT_NONE);
    item.kind  = action;
    item.data  = data_byte;
    item.mack  = master_ack;
    item.bus   = bus_in;
  end
endmodule

// ----- rtl/swebm_queue.sv -----
module swebm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  swebm_pkg::item_t push_item,
  output logic             full,
  output logic             q_valid,
  input  logic             pop,
  output swebm_pkg::item_t head
);
  import swebm_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- rtl/swebm_seq.sv -----
module swebm_seq #(
  parameter int W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  swebm_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  swebm_pkg::item_t head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             bus_drive,
  output logic             drive_enable,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rd_byte,
  output logic [2:0]       status
);
  import swebm_pkg::*;
  `include "single_wire_eeprom_bus_master_unit_defines.svh"

  localparam int CW = ((W > 16) ? W : 16) + 1;

  phase_t     phase, phase_next;
  logic [W-1:0] tick_count, tick_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       first_sample, first_sample_next;
  logic       ack_choice, ack_choice_next;
  logic [2:0] last_status, last_status_next;
  logic [1:0] kind, kind_next;
  logic       drive_c, enable_c, done_c;
  logic [7:0] rdata_c;

  // Segment ends on this tick: zero length counts as one, long lengths saturate.
  function automatic logic seg_end(input logic [W-1:0] tc, input logic [15:0] len);
    logic [CW-1:0] lx;
    logic [CW-1:0] tmax;
    logic [CW-1:0] tc1;
    lx   = (len == 16'd0) ? CW'(1) : CW'(len);
    tmax = CW'({W{1'b1}});
    if (lx > tmax) begin
      lx = tmax;
    end
    tc1 = CW'(tc) + CW'(1);
    return tc1 >= lx;
  endfunction

  assign pop = q_valid && (!res_valid || !res_stall);

  always_comb begin
    logic [15:0] len;
    logic        fin;
    logic [2:0]  fin_code;
    logic        seg;

    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    first_sample_next = first_sample;
    ack_choice_next   = ack_choice;
    last_status_next  = last_status;
    kind_next         = kind;
    drive_c           = 1'b1;
    enable_c          = 1'b1;
    done_c            = 1'b0;
    rdata_c           = 8'd0;
    fin               = 1'b0;
    fin_code          = ST_OK;

    if (phase == PH_IDLE && head.start) begin
      kind_next         = head.kind;
      bit_count_next    = 4'd0;
      first_sample_next = 1'b0;
      tick_count_next   = '0;
      case (head.kind)
        ACT_HEADER: begin
          shift_byte_next = START_HEADER_BYTE;
          ack_choice_next = 1'b1;
          phase_next      = PH_HLOW1;
        end
        ACT_WRITE: begin
          shift_byte_next = head.data;
          ack_choice_next = head.mack;
          phase_next      = PH_WR1;
        end
        default: begin
          shift_byte_next = 8'd0;
          ack_choice_next = head.mack;
          phase_next      = PH_RDA;
        end
      endcase
    end

    case (phase_next)
      PH_HLOW1, PH_HLOW2: len = cfg.header_low;
      PH_STBY:            len = cfg.standby;
      PH_RDA:             len = cfg.read_first;
      PH_RDT:             len = cfg.read_tail;
      PH_SW:              len = cfg.ack_timeout;
      default:            len = cfg.half_bit;
    endcase
    seg = seg_end(tick_count_next, len);

    case (phase_next)
      PH_IDLE: begin
      end
      PH_HLOW1: begin
        drive_c = 1'b0;
        if (seg) begin
          phase_next = PH_STBY;
        end
      end
      PH_STBY: begin
        if (seg) begin
          phase_next = PH_HLOW2;
        end
      end
      PH_HLOW2: begin
        drive_c = 1'b0;
        if (seg) begin
          phase_next = PH_WR1;
        end
      end
      PH_WR1: begin
        drive_c = !shift_byte_next[MSB_BIT];
        if (seg) begin
          phase_next = PH_WR2;
        end
      end
      PH_WR2: begin
        drive_c = shift_byte_next[MSB_BIT];
        if (seg) begin
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          bit_count_next  = bit_count_next + 4'd1;
          phase_next      = (bit_count_next >= BITS_PER_BYTE) ? PH_MK1 : PH_WR1;
        end
      end
      PH_RDA: begin
        enable_c = 1'b0;
        if (seg) begin
          first_sample_next = head.bus;
          phase_next        = PH_RDB;
        end
      end
      PH_RDB: begin
        enable_c = 1'b0;
        if (seg) begin
          if (head.bus == first_sample_next) begin
            shift_byte_next = 8'd0;
            fin             = 1'b1;
            fin_code        = first_sample_next ? ST_READ_HIGH_HIGH : ST_READ_LOW_LOW;
          end else begin
            shift_byte_next = {shift_byte_next[6:0], !first_sample_next};
            bit_count_next  = bit_count_next + 4'd1;
            if (cfg.read_tail != 16'd0) begin
              phase_next = PH_RDT;
            end else begin
              phase_next = (bit_count_next >= BITS_PER_BYTE) ? PH_MK1 : PH_RDA;
            end
          end
        end
      end
      PH_RDT: begin
        enable_c = 1'b0;
        if (seg) begin
          phase_next = (bit_count_next >= BITS_PER_BYTE) ? PH_MK1 : PH_RDA;
        end
      end
      PH_MK1: begin
        drive_c = !ack_choice_next;
        if (seg) begin
          phase_next = PH_MK2;
        end
      end
      PH_MK2: begin
        drive_c = ack_choice_next;
        if (seg) begin
          phase_next = PH_SW;
        end
      end
      PH_SW: begin
        enable_c = 1'b0;
        if (head.bus == (kind_next == ACT_HEADER)) begin
          phase_next = PH_SH1;
          seg        = 1'b1;
        end else if (seg) begin
          fin      = 1'b1;
          fin_code = (kind_next == ACT_HEADER) ? ST_NOACK_TIMEOUT : ST_ACK_TIMEOUT;
        end
      end
      PH_SH1: begin
        enable_c = 1'b0;
        if (seg) begin
          phase_next = PH_SH2;
        end
      end
      PH_SH2: begin
        enable_c = 1'b0;
        if (seg) begin
          fin = 1'b1;
          if (head.bus) begin
            fin_code = ST_OK;
          end else begin
            fin_code = (kind_next == ACT_HEADER) ? ST_NOACK_LOW : ST_ACK_NO_RISE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        seg        = 1'b0;
      end
    endcase

    // Advance or restart the tick counter; idle holds it.
    if (phase_next != PH_IDLE || phase != PH_IDLE) begin
      tick_count_next = seg ? '0 : tick_count_next + W'(1);
    end

    if (fin) begin
      last_status_next = fin_code;
      done_c           = 1'b1;
      if (kind_next == ACT_READ) begin
        rdata_c = shift_byte_next;
      end
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      first_sample <= 1'b0;
      ack_choice   <= 1'b0;
      last_status  <= ST_OK;
      kind         <= ACT_HEADER;
      res_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_count    <= bit_count_next;
        shift_byte   <= shift_byte_next;
        first_sample <= first_sample_next;
        ack_choice   <= ack_choice_next;
        last_status  <= last_status_next;
        kind         <= kind_next;
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bus_drive    <= drive_c;
      drive_enable <= enable_c;
      busy_res     <= (phase_next != PH_IDLE);
      done_res     <= done_c;
      rd_byte      <= rdata_c;
      status       <= last_status_next;
    end
  end

  `SWEBM_ASSERT_NOW(a_done_not_busy, res_valid && done_res, !busy_res, "done while busy")
  `SWEBM_ASSERT_NOW(a_rdata_on_done, res_valid && (rd_byte != 8'd0), done_res, "read data off done")
  `SWEBM_ASSERT_NOW(a_release_in_cmd, res_valid && !drive_enable, busy_res || done_res, "bus released while idle")
  `SWEBM_ASSERT_NEXT(a_hold_no_pop, !pop, $stable(phase) && $stable(tick_count), "state moved without pop")
endmodule

// ----- rtl/single_wire_eeprom_bus_master_unit.sv -----
// Path: an accepted tick is written into the queue, then worked by the sequencer when popped,
// and its result is registered in the output registers, which hold it while res_stall is high.
// Throughput: one tick per cycle, sustained, while the result side takes one per cycle.
// Each tick is worked by the phase sequencer; a two-entry queue absorbs stalls.
// Reset (rst, synchronous, active high): sequencer idle, queue empty, config registers to defaults.
module single_wire_eeprom_bus_master_unit #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       tick_valid,
  output logic       tick_stall,
  input  logic       cmd_valid,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic       master_ack,
  input  logic       bus_in,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       bus_drive,
  output logic       drive_enable,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rd_byte,
  output logic [2:0] status
);
  import swebm_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t head;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;

  // Register writes are always accepted; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit    <= RST_HALF_BIT;
      cfg.read_first  <= RST_READ_FIRST;
      cfg.read_tail   <= RST_READ_TAIL;
      cfg.ack_timeout <= RST_ACK_TIMEOUT;
      cfg.standby     <= RST_STANDBY;
      cfg.header_low  <= RST_HEADER_LOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_BIT:    cfg.half_bit    <= cfg_data;
        REG_READ_FIRST:  cfg.read_first  <= cfg_data;
        REG_READ_TAIL:   cfg.read_tail   <= cfg_data;
        REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data;
        REG_STANDBY:     cfg.standby     <= cfg_data;
        REG_HEADER_LOW:  cfg.header_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: take a tick transfer and classify its command.
  swebm_front u_front (
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .cmd_valid  (cmd_valid),
    .action     (action),
    .data_byte  (data_byte),
    .master_ack (master_ack),
    .bus_in     (bus_in),
    .q_full     (q_full),
    .push       (push),
    .item       (front_item)
  );

  // Short queue so the front and the sequencer stall independently.
  swebm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .head      (head)
  );

  // Back: phase sequencer driving the bus and registering each result transfer.
  swebm_seq #(
    .W (TICK_COUNTER_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .bus_drive    (bus_drive),
    .drive_enable (drive_enable),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rd_byte      (rd_byte),
    .status       (status)
  );
endmodule
